>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/nlr_pkg.sv
// Package: parse phases, status codes and character classes of the recognizer.
`timescale 1ns / 1ps

package nlr_pkg;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_START   = 14'b00000000000010,
        PH_SIGNED  = 14'b00000000000100,
        PH_ZERO    = 14'b00000000001000,
        PH_HEX     = 14'b00000000010000,
        PH_BIN     = 14'b00000000100000,
        PH_OCT     = 14'b00000001000000,
        PH_DEC     = 14'b00000010000000,
        PH_DEN     = 14'b00000100000000,
        PH_POINT   = 14'b00001000000000,
        PH_EXP     = 14'b00010000000000,
        PH_EXPSIGN = 14'b00100000000000,
        PH_EXPDIG  = 14'b01000000000000,
        PH_SUFFIX  = 14'b10000000000000
    } phase_t;

    typedef enum logic [1:0] {
        ST_LEGAL   = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_LONG    = 2'd2
    } status_t;

    localparam int LEN_W = 10;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_B  = 8'h42;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_I  = 8'h49;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_hexdig(input logic [7:0] c);
        return is_dig(c) || ((c >= CH_LC_A) && (c <= CH_LC_F))
            || ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

endpackage

>>> hw/rtl/nlr_if.sv
// Interfaces: character beat channel and result beat channel.
`timescale 1ns / 1ps

interface nlr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;
    logic       allow_imag;
    logic       allow_slash;

    modport source (output valid, output ch, output first, output allow_imag,
                    output allow_slash, input ready);
    modport sink   (input valid, input ch, input first, input allow_imag,
                    input allow_slash, output ready);
endinterface

interface nlr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] length;

    modport source (output valid, output status, output length, input ready);
    modport sink   (input valid, input status, input length, output ready);
endinterface

>>> hw/rtl/numeric_literal_recognizer.sv
// Top level: numeric literal recognizer, one character beat per cycle unless results stall.
`timescale 1ns / 1ps
//
// Usage:
//   chars   - sink of character beats (ch, first, allow_imag, allow_slash).
//             A beat with first set starts a new number and latches the
//             imaginary and slash options; beats with first clear continue it.
//   results - source of result beats (status, length), at most one per number.
//             status: legal, illegal format, or longer than MAX_LENGTH.
//             length counts characters of a legal number, ending one excluded.
// Path: a character beat is registered in the input stage, then the parse
//   step writes the result register from it.
// Throughput: one character per cycle while results are taken, set by the
//   combinational parse step between the input register and the result register.
// Stall: while a result waits and results.ready is low, the input stage holds
//   its beat and chars.ready drops once that stage is full; no beat is lost.
// Reset: rst_n clears both stages and returns the parser to idle; beats without
//   first are ignored while idle or after a number has ended.
// Length counter width follows MAX_LENGTH; length reports its low 10 bits.

`include "assert_macros.svh"

module numeric_literal_recognizer
    import nlr_pkg::*;
#(
    parameter int MAX_LENGTH = 1023
) (
    input  logic          clk,
    input  logic          rst_n,
    nlr_char_if.sink      chars,
    nlr_result_if.source  results
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_first_reg;
    logic       s1_imag_reg;
    logic       s1_slash_reg;

    // Parser state
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            imag_reg, imag_next;
    logic            slash_reg, slash_next;

    // Result register
    logic             out_valid_reg;
    status_t          status_reg, status_next;
    logic [LEN_W-1:0] length_reg, length_next;

    logic step;       // input stage beat is consumed by the parser this cycle
    logic emit;       // the step ends the number

    assign step         = s1_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready  = !s1_valid_reg || step;

    assign results.valid  = out_valid_reg;
    assign results.status = status_reg;
    assign results.length = length_reg;

    // Parse step: collapse the fall-through phases, then act once.
    always_comb
    begin
        phase_t                  p;
        logic [CW-1:0]           cnt;
        logic                    done;
        logic                    adv;
        phase_t                  adv_ph;
        logic                    fin;
        status_t                 fin_st;
        logic                    sfx_end;
        logic [7:0]              c;
        logic [CW+LEN_W-1:0]     cnt_ext;

        c          = s1_ch_reg;
        p          = s1_first_reg ? PH_START : phase_reg;
        cnt        = s1_first_reg ? '0 : count_reg;
        imag_next  = s1_first_reg ? s1_imag_reg : imag_reg;
        slash_next = s1_first_reg ? s1_slash_reg : slash_reg;
        done       = 1'b0;
        adv        = 1'b0;
        adv_ph     = PH_IDLE;
        fin        = 1'b0;
        fin_st     = ST_LEGAL;
        sfx_end    = 1'b0;

        if (p == PH_START)
        begin
            if (is_sign(c))
            begin
                adv = 1'b1; adv_ph = PH_SIGNED; done = 1'b1;
            end
            else
            begin
                p = PH_SIGNED;
            end
        end
        if (!done && p == PH_SIGNED)
        begin
            if (is_sign(c))
            begin
                fin = 1'b1; fin_st = ST_ILLEGAL; done = 1'b1;
            end
            else if (c == CH_0)
            begin
                adv = 1'b1; adv_ph = PH_ZERO; done = 1'b1;
            end
            else
            begin
                p = PH_DEC;
            end
        end
        if (!done && p == PH_ZERO)
        begin
            if (c == CH_LC_X || c == CH_UC_X)
            begin
                adv = 1'b1; adv_ph = PH_HEX; done = 1'b1;
            end
            else if (c == CH_LC_B || c == CH_UC_B)
            begin
                adv = 1'b1; adv_ph = PH_BIN; done = 1'b1;
            end
            else
            begin
                p = is_dig(c) ? PH_OCT : PH_DEC;
            end
        end

        if (!done)
        begin
            case (p)
                PH_HEX:
                begin
                    if (is_hexdig(c)) begin adv = 1'b1; adv_ph = PH_HEX; end
                    else sfx_end = 1'b1;
                end
                PH_BIN:
                begin
                    if (c == CH_0 || c == CH_1) begin adv = 1'b1; adv_ph = PH_BIN; end
                    else sfx_end = 1'b1;
                end
                PH_OCT:
                begin
                    if (c >= CH_0 && c <= CH_7) begin adv = 1'b1; adv_ph = PH_OCT; end
                    else sfx_end = 1'b1;
                end
                PH_DEC:
                begin
                    if (is_dig(c)) begin adv = 1'b1; adv_ph = PH_DEC; end
                    else if (c == CH_SLASH && slash_next) begin adv = 1'b1; adv_ph = PH_DEN; end
                    else if (c == CH_POINT) begin adv = 1'b1; adv_ph = PH_POINT; end
                    else if (c == CH_LC_E || c == CH_UC_E) begin adv = 1'b1; adv_ph = PH_EXP; end
                    else sfx_end = 1'b1;
                end
                PH_DEN:
                begin
                    if (is_dig(c)) begin adv = 1'b1; adv_ph = PH_DEN; end
                    else sfx_end = 1'b1;
                end
                PH_POINT:
                begin
                    if (is_dig(c)) begin adv = 1'b1; adv_ph = PH_POINT; end
                    else if (c == CH_LC_E || c == CH_UC_E) begin adv = 1'b1; adv_ph = PH_EXP; end
                    else sfx_end = 1'b1;
                end
                PH_EXP:
                begin
                    if (is_sign(c)) begin adv = 1'b1; adv_ph = PH_EXPSIGN; end
                    else if (is_dig(c)) begin adv = 1'b1; adv_ph = PH_EXPDIG; end
                    else sfx_end = 1'b1;
                end
                PH_EXPSIGN:
                begin
                    if (is_sign(c)) begin fin = 1'b1; fin_st = ST_ILLEGAL; end
                    else if (is_dig(c)) begin adv = 1'b1; adv_ph = PH_EXPDIG; end
                    else sfx_end = 1'b1;
                end
                PH_EXPDIG:
                begin
                    if (is_dig(c)) begin adv = 1'b1; adv_ph = PH_EXPDIG; end
                    else sfx_end = 1'b1;
                end
                PH_SUFFIX:
                begin
                    fin = 1'b1;
                    fin_st = (c == CH_POINT || (c == CH_SLASH && slash_next) || is_dig(c)
                              || is_letter(c)) ? ST_ILLEGAL : ST_LEGAL;
                end
                default:
                begin
                    // idle: beat ignored
                end
            endcase
        end

        // Optional i suffix, else judge the ending character.
        if (sfx_end)
        begin
            if ((c == CH_LC_I || c == CH_UC_I) && imag_next)
            begin
                adv = 1'b1; adv_ph = PH_SUFFIX;
            end
            else
            begin
                fin = 1'b1;
                fin_st = (c == CH_POINT || (c == CH_SLASH && slash_next) || is_dig(c)
                          || is_letter(c)) ? ST_ILLEGAL : ST_LEGAL;
            end
        end

        // Taking a character at the length limit ends the number as too long.
        if (adv && cnt >= CW'(MAX_LENGTH))
        begin
            adv = 1'b0; fin = 1'b1; fin_st = ST_LONG;
        end

        cnt_ext     = {{LEN_W{1'b0}}, cnt};
        emit        = fin;
        status_next = fin_st;
        length_next = (fin_st == ST_LEGAL) ? cnt_ext[LEN_W-1:0] : '0;
        count_next  = adv ? CW'(cnt + 1'b1) : cnt;
        if (fin)
            phase_next = PH_IDLE;
        else if (adv)
            phase_next = adv_ph;
        else if (p == PH_IDLE)
            phase_next = PH_IDLE;
        else
            phase_next = p;
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (chars.ready)
            s1_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_ch_reg    <= chars.ch;
            s1_first_reg <= chars.first;
            s1_imag_reg  <= chars.allow_imag;
            s1_slash_reg <= chars.allow_slash;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            imag_reg  <= 1'b0;
            slash_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            imag_reg  <= imag_next;
            slash_reg <= slash_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && emit)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            status_reg <= status_next;
            length_reg <= length_next;
        end
    end

    // Checks
    `ASSERT_NEXT(a_end_goes_idle, clk, rst_n, step && emit, phase_reg == PH_IDLE && out_valid_reg)
    `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !step, s1_valid_reg && $stable(s1_ch_reg) && $stable(s1_first_reg))
    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_LENGTH))
    `ASSERT_IMPLY(a_len_zero_bad, clk, rst_n, out_valid_reg && status_reg != ST_LEGAL, length_reg == '0)

endmodule

>>> sim/numeric_literal_recognizer_checker.sv
// Checker: watches both channels, predicts each number's verdict and compares it.
`timescale 1ns / 1ps

module numeric_literal_recognizer_checker
    import nlr_pkg::*;
#(
    parameter int MAX_CHARS = 1023
) (
    input  logic   clk,
    input  logic   rst_n,
    nlr_char_if    chars,
    nlr_result_if  results,
    output int     mismatches,
    output int     outstanding,
    output int     legal_seen,
    output int     illegal_seen,
    output int     long_seen
);

    typedef struct packed {
        status_t    status;
        logic [9:0] length;
    } verdict_t;

    verdict_t    pending_verdicts[$];

    phase_t      scan_phase = PH_IDLE;
    int unsigned char_total = 0;
    logic        imag_on = 1'b0;
    logic        slash_on = 1'b0;

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        legal_seen   = 0;
        illegal_seen = 0;
        long_seen    = 0;
    end

    function automatic logic char_is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic char_is_alpha(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic char_is_sign(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic char_is_hex(input logic [7:0] c);
        return char_is_digit(c) || (c >= CH_LC_A && c <= CH_LC_F)
            || (c >= CH_UC_A && c <= CH_UC_F);
    endfunction

    // Number is over: queue its verdict and go idle.
    task automatic emit(input status_t st);
        verdict_t v;
        v.status = st;
        v.length = (st == ST_LEGAL) ? char_total[9:0] : 10'd0;
        pending_verdicts.push_back(v);
        scan_phase = PH_IDLE;
    endtask

    task automatic grow_to(input phase_t nxt);
        if (char_total >= MAX_CHARS)
            emit(ST_LONG);
        else
        begin
            char_total++;
            scan_phase = nxt;
        end
    endtask

    task automatic judge_end(input logic [7:0] c);
        if (c == CH_POINT || (c == CH_SLASH && slash_on) || char_is_digit(c)
            || char_is_alpha(c))
            emit(ST_ILLEGAL);
        else
            emit(ST_LEGAL);
    endtask

    task automatic close_or_suffix(input logic [7:0] c);
        if ((c == CH_LC_I || c == CH_UC_I) && imag_on)
            grow_to(PH_SUFFIX);
        else
            judge_end(c);
    endtask

    // One character beat through the syntax tracker.
    task automatic scan_char(input logic [7:0] c, input logic first,
                             input logic imag, input logic slash);
        logic again;
        if (first)
        begin
            scan_phase = PH_START;
            char_total = 0;
            imag_on    = imag;
            slash_on   = slash;
        end
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (scan_phase)
                PH_START:
                    if (char_is_sign(c))
                        grow_to(PH_SIGNED);
                    else
                    begin
                        scan_phase = PH_SIGNED;
                        again = 1'b1;
                    end
                PH_SIGNED:
                    if (char_is_sign(c))
                        emit(ST_ILLEGAL);
                    else if (c == CH_0)
                        grow_to(PH_ZERO);
                    else
                    begin
                        scan_phase = PH_DEC;
                        again = 1'b1;
                    end
                PH_ZERO:
                    if (c == CH_LC_X || c == CH_UC_X)
                        grow_to(PH_HEX);
                    else if (c == CH_LC_B || c == CH_UC_B)
                        grow_to(PH_BIN);
                    else
                    begin
                        scan_phase = char_is_digit(c) ? PH_OCT : PH_DEC;
                        again = 1'b1;
                    end
                PH_HEX:
                    if (char_is_hex(c))
                        grow_to(PH_HEX);
                    else
                        close_or_suffix(c);
                PH_BIN:
                    if (c == CH_0 || c == CH_1)
                        grow_to(PH_BIN);
                    else
                        close_or_suffix(c);
                PH_OCT:
                    if (c >= CH_0 && c <= CH_7)
                        grow_to(PH_OCT);
                    else
                        close_or_suffix(c);
                PH_DEC:
                    if (char_is_digit(c))
                        grow_to(PH_DEC);
                    else if (c == CH_SLASH && slash_on)
                        grow_to(PH_DEN);
                    else if (c == CH_POINT)
                        grow_to(PH_POINT);
                    else if (c == CH_LC_E || c == CH_UC_E)
                        grow_to(PH_EXP);
                    else
                        close_or_suffix(c);
                PH_DEN:
                    if (char_is_digit(c))
                        grow_to(PH_DEN);
                    else
                        close_or_suffix(c);
                PH_POINT:
                    if (char_is_digit(c))
                        grow_to(PH_POINT);
                    else if (c == CH_LC_E || c == CH_UC_E)
                        grow_to(PH_EXP);
                    else
                        close_or_suffix(c);
                PH_EXP:
                    if (char_is_sign(c))
                        grow_to(PH_EXPSIGN);
                    else if (char_is_digit(c))
                        grow_to(PH_EXPDIG);
                    else
                        close_or_suffix(c);
                PH_EXPSIGN:
                    if (char_is_sign(c))
                        emit(ST_ILLEGAL);
                    else if (char_is_digit(c))
                        grow_to(PH_EXPDIG);
                    else
                        close_or_suffix(c);
                PH_EXPDIG:
                    if (char_is_digit(c))
                        grow_to(PH_EXPDIG);
                    else
                        close_or_suffix(c);
                PH_SUFFIX:
                    judge_end(c);
                default:
                    scan_phase = PH_IDLE;
            endcase
        end
    endtask

    task automatic flag_error(input string msg);
        mismatches <= mismatches + 1;
        if (mismatches < 10)
            $display("%t ERROR %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            pending_verdicts.delete();
            scan_phase = PH_IDLE;
            char_total = 0;
            imag_on    = 1'b0;
            slash_on   = 1'b0;
            outstanding <= 0;
        end
        else
        begin
            if (chars.valid && chars.ready)
                scan_char(chars.ch, chars.first, chars.allow_imag, chars.allow_slash);
            if (results.valid && results.ready)
            begin
                if (pending_verdicts.size() == 0)
                    flag_error($sformatf("unexpected result: status %0d length %0d",
                                         results.status, results.length));
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (results.status !== want.status || results.length !== want.length)
                        flag_error($sformatf(
                            "expected status %0d length %0d, got status %0d length %0d",
                            want.status, want.length, results.status, results.length));
                end
                case (results.status)
                    ST_LEGAL:   legal_seen   <= legal_seen + 1;
                    ST_ILLEGAL: illegal_seen <= illegal_seen + 1;
                    default:    long_seen    <= long_seen + 1;
                endcase
            end
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

>>> sim/numeric_literal_recognizer_test.sv
// Testbench top: drives character beats into the recognizer and gives the verdict.
`timescale 1ns / 1ps

module numeric_literal_recognizer_test;
    import nlr_pkg::*;

    localparam int LEN_LIMIT  = 1023;
    localparam int RAND_BEATS = 1100;
    // Cycles in a row with no handshake on either channel before the run is
    // called hung; far above any random idle stretch.
    localparam int STALL_LIMIT = 1000;
    // The result passes the input stage and the result register after the ending beat; leave room for stalls.
    localparam int DRAIN_CYCLES = 16;

    // Ending characters that are not part of any number.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HIGH  = 8'h80;
    localparam logic [7:0] CH_MAX   = 8'hFF;

    typedef logic [7:0] text_t[$];

    logic clk;
    logic rst_n;
    logic calm;         // 1: neither side idles

    int mismatches;
    int outstanding;
    int legal_seen;
    int illegal_seen;
    int long_seen;
    int beats_sent;
    int numbers_sent;
    int quiet_cycles;

    nlr_char_if   chars();
    nlr_result_if results();

    numeric_literal_recognizer #(
        .MAX_LENGTH(LEN_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    numeric_literal_recognizer_checker #(
        .MAX_CHARS(LEN_LIMIT)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .chars        (chars),
        .results      (results),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .legal_seen   (legal_seen),
        .illegal_seen (illegal_seen),
        .long_seen    (long_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: ready is low with a chance of 28 in 100 unless in a calm stretch.
    always @(posedge clk)
        results.ready <= calm || ($urandom_range(99) >= 28);

    // Watchdog: too many cycles with no beat moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (chars.valid && chars.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // One character beat. Random idle cycles come first; valid then stays
    // high until the beat is taken. Options on continuation beats are noise,
    // the block must ignore them.
    task automatic send_beat(input logic [7:0] c, input logic first,
                             input logic imag, input logic slash);
        if (!calm)
            while ($urandom_range(99) < 28)
            begin
                chars.valid <= 1'b0;
                @(posedge clk);
            end
        chars.valid       <= 1'b1;
        chars.ch          <= c;
        chars.first       <= first;
        chars.allow_imag  <= first ? imag : logic'($urandom_range(1));
        chars.allow_slash <= first ? slash : logic'($urandom_range(1));
        do
            @(posedge clk);
        while (!chars.ready);
        beats_sent++;
        if (first)
            numbers_sent++;
    endtask

    task automatic send_word(input text_t w, input logic imag, input logic slash);
        foreach (w[i])
            send_beat(w[i], i == 0, imag, slash);
    endtask

    // A number body plus its ending character.
    task automatic send_number(input string body, input logic [7:0] ending,
                               input logic imag, input logic slash);
        text_t w;
        for (int i = 0; i < body.len(); i++)
            w.push_back(body[i]);
        w.push_back(ending);
        send_word(w, imag, slash);
    endtask

    task automatic add_digits(inout text_t w, input string set,
                              input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n)
            w.push_back(pick(set));
    endtask

    initial
    begin
        text_t w;
        int    kind;
        logic  imag;
        logic  slash;
        int    stop_at;

        clk               = 1'b0;
        rst_n             = 1'b0;
        calm              = 1'b0;
        beats_sent        = 0;
        numbers_sent      = 0;
        quiet_cycles      = 0;
        chars.valid       = 1'b0;
        chars.ch          = CH_NUL;
        chars.first       = 1'b0;
        chars.allow_imag  = 1'b0;
        chars.allow_slash = 1'b0;
        results.ready     = 1'b0;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part ----
        // Continuation beats while idle must vanish.
        send_beat(CH_7, 1'b0, 1'b1, 1'b1);
        send_beat(CH_SPACE, 1'b0, 1'b0, 1'b0);
        // Every form, upper and lower case markers.
        send_number("+0x1fA", CH_SPACE, 1'b0, 1'b0);
        send_number("0X9F", CH_COMMA, 1'b0, 1'b0);
        send_number("-0b101i", CH_SEMI, 1'b1, 1'b0);
        send_number("0B1", CH_NL, 1'b0, 1'b0);
        send_number("017", CH_SPACE, 1'b0, 1'b0);
        send_number("12/34I", CH_COMMA, 1'b1, 1'b1);
        send_number("3.14e+10", CH_TAB, 1'b0, 1'b0);
        send_number("1.5E-3i", CH_SPACE, 1'b1, 1'b0);
        // Octal with 8 or 9: the digit ends the number illegally.
        send_number("0", CH_9, 1'b0, 1'b0);
        // Slash without the option just ends the number.
        send_number("12", CH_SLASH, 1'b0, 1'b0);
        // Slash with the option is an illegal ending after the denominator.
        send_number("1/2", CH_SLASH, 1'b0, 1'b1);
        // Doubled signs: leading and exponent.
        send_number("+", CH_MINUS, 1'b0, 1'b0);
        send_number("1e-", CH_PLUS, 1'b0, 1'b0);
        // Empty bodies: lone sign, bare prefixes, empty exponent, empty number.
        send_number("-", CH_SPACE, 1'b0, 1'b0);
        send_number("0x", CH_HIGH, 1'b0, 1'b0);
        send_number("0b", CH_MAX, 1'b0, 1'b0);
        send_number("7e", CH_SPACE, 1'b0, 1'b0);
        send_number("", CH_NUL, 1'b1, 1'b1);
        // Bad followers: letter, point, suffix without option, second suffix.
        send_number("12", CH_LC_A, 1'b0, 1'b0);
        send_number("1.2", CH_POINT, 1'b0, 1'b0);
        send_number("5", CH_LC_I, 1'b0, 1'b0);
        send_number("5i", CH_UC_I, 1'b1, 1'b0);
        // Beats after a result are ignored until the next first beat.
        send_number("1", CH_SPACE, 1'b0, 1'b0);
        send_beat(CH_1, 1'b0, 1'b0, 1'b0);
        send_beat(CH_SPACE, 1'b0, 1'b0, 1'b0);
        // Restart in mid-parse drops the old number without a result.
        send_beat(CH_9, 1'b1, 1'b0, 1'b0);
        send_beat(CH_9, 1'b0, 1'b0, 1'b0);
        send_number("0", CH_SPACE, 1'b0, 1'b0);

        // ---- Random part ----
        // The first stretch runs with no idling on either side.
        calm    = 1'b1;
        stop_at = beats_sent + RAND_BEATS;
        while (beats_sent < stop_at)
        begin
            if (beats_sent > stop_at - RAND_BEATS * 3 / 4)
                calm = 1'b0;
            w.delete();
            kind  = $urandom_range(99);
            imag  = logic'($urandom_range(1));
            slash = logic'($urandom_range(1));
            if (kind < 75)
            begin
                // Well-formed number with random content and a random ending.
                if ($urandom_range(3) == 0)
                    w.push_back(pick("+-"));
                case ($urandom_range(5))
                    0:
                    begin
                        w.push_back(CH_0);
                        w.push_back(pick("xX"));
                        add_digits(w, "0123456789abcdefABCDEF", 0, 5);
                    end
                    1:
                    begin
                        w.push_back(CH_0);
                        w.push_back(pick("bB"));
                        add_digits(w, "01", 0, 6);
                    end
                    2:
                    begin
                        w.push_back(CH_0);
                        add_digits(w, "01234567", 1, 5);
                    end
                    3:
                    begin
                        add_digits(w, "0123456789", 1, 4);
                        w.push_back(CH_SLASH);
                        add_digits(w, "0123456789", 0, 4);
                    end
                    4:
                    begin
                        add_digits(w, "0123456789", 1, 4);
                        if ($urandom_range(1))
                        begin
                            w.push_back(CH_POINT);
                            add_digits(w, "0123456789", 0, 3);
                        end
                        if ($urandom_range(1))
                        begin
                            w.push_back(pick("eE"));
                            if ($urandom_range(1))
                                w.push_back(pick("+-"));
                            add_digits(w, "0123456789", 0, 3);
                        end
                    end
                    default:
                        add_digits(w, "0123456789", 0, 6);
                endcase
                if (imag && $urandom_range(1))
                    w.push_back(pick("iI"));
                if ($urandom_range(3) == 0)
                    w.push_back(8'($urandom_range(255)));
                else
                    w.push_back(pick(" ,;)\t\n"));
                send_word(w, imag, slash);
            end
            else if (kind < 85)
            begin
                // Broken sequence from the characters the parser cares about.
                add_digits(w, "+-0123456789.eEiIxXbB/ ", 1, 6);
                w.push_back(8'($urandom_range(255)));
                send_word(w, imag, slash);
            end
            else if (kind < 92)
            begin
                // Partial number cut short by the next first beat.
                add_digits(w, "+-0123456789.eE/", 1, 4);
                send_word(w, imag, slash);
            end
            else
            begin
                // Raw noise, first set at random.
                repeat ($urandom_range(4, 1))
                    send_beat(8'($urandom_range(255)), logic'($urandom_range(1)),
                              logic'($urandom_range(1)), logic'($urandom_range(1)));
            end
        end

        // ---- Length limit ----
        // Exactly at the limit is still legal; one more character overflows.
        w.delete();
        repeat (LEN_LIMIT)
            w.push_back(CH_1);
        w.push_back(CH_SPACE);
        send_word(w, 1'b0, 1'b0);
        w.delete();
        repeat (LEN_LIMIT + 1)
            w.push_back(CH_1);
        w.push_back(CH_SPACE);
        send_word(w, 1'b0, 1'b0);

        chars.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d character beats forming %0d numbers.", beats_sent, numbers_sent);
        $display("Results: %0d legal, %0d illegal, %0d too long; %0d mismatches.",
                 legal_seen, illegal_seen, long_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nlr_pkg.sv
hw/rtl/nlr_if.sv
hw/rtl/numeric_literal_recognizer.sv
sim/numeric_literal_recognizer_checker.sv
sim/numeric_literal_recognizer_test.sv
